// ----- design/scalc_pkg.sv -----
// ----------------------------------------------------------------------------
// scalc_pkg
// Shared types and constants of the stack calculator: operation and status
// codes, item structs and the request struct of the arithmetic unit.
// ----------------------------------------------------------------------------
package scalc_pkg;

    localparam int SCALC_STACK_DEPTH = 1024;
    localparam int SCALC_DATA_W      = 32;
    localparam int SCALC_INDEX_W     = 10;
    localparam int SCALC_DEPTH_W     = 11;
    localparam int SCALC_STEP_W      = $clog2(SCALC_DATA_W);

    typedef enum logic [2:0] {
        OP_PUSH  = 3'd0,
        OP_POP   = 3'd1,
        OP_RTOP  = 3'd2,
        OP_RBOT  = 3'd3,
        OP_ADD   = 3'd4,
        OP_SUB   = 3'd5,
        OP_MUL   = 3'd6,
        OP_DIV   = 3'd7
    } t_op;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_EMPTY   = 3'd1,
        ST_RANGE   = 3'd2,
        ST_FEW     = 3'd3,
        ST_DIVZERO = 3'd4,
        ST_FULL    = 3'd5
    } t_status;

    typedef struct packed {
        t_op                              op;
        logic signed [SCALC_DATA_W-1:0]   value;
        logic        [SCALC_INDEX_W-1:0]  index;
    } t_in_item;

    typedef struct packed {
        logic signed [SCALC_DATA_W-1:0]   result;
        t_status                          status;
        logic        [SCALC_DEPTH_W-1:0]  depth;
    } t_out_item;

    typedef struct packed {
        logic start;
        t_op  op;
    } t_alu_req;

endpackage

// ----- design/scalc_mem.sv -----
// ----------------------------------------------------------------------------
// scalc_mem
// Stack word store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module scalc_mem #(
    parameter int DEPTH  = scalc_pkg::SCALC_STACK_DEPTH,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic                                i_clk,
    input  logic                                i_we,
    input  logic [ADDR_W-1:0]                   i_waddr,
    input  logic [scalc_pkg::SCALC_DATA_W-1:0]  i_wdata,
    input  logic [ADDR_W-1:0]                   i_raddr,
    output logic [scalc_pkg::SCALC_DATA_W-1:0]  o_rdata
);
    import scalc_pkg::*;

    logic [SCALC_DATA_W-1:0] r_mem [DEPTH];
    logic [SCALC_DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/scalc_alu.sv -----
// ----------------------------------------------------------------------------
// scalc_alu
// Iterative arithmetic unit built around one 33-bit adder. Add and subtract
// take one pass, multiply is shift-and-add over 32 steps, divide is
// restoring division on magnitudes with a floor correction at the end.
// ----------------------------------------------------------------------------
module scalc_alu (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  scalc_pkg::t_alu_req                 i_req,
    input  logic [scalc_pkg::SCALC_DATA_W-1:0]  i_a,
    input  logic [scalc_pkg::SCALC_DATA_W-1:0]  i_b,
    output logic                                o_done,
    output logic [scalc_pkg::SCALC_DATA_W-1:0]  o_result
);
    import scalc_pkg::*;

    localparam int DW = SCALC_DATA_W;

    typedef enum logic [2:0] {
        A_IDLE, A_PREPA, A_PREPB, A_MUL, A_DIV, A_FIX, A_DONE
    } t_state;

    t_state                  r_state;
    logic [DW-1:0]           r_x;      // multiplicand, or dividend/quotient
    logic [DW-1:0]           r_y;      // multiplier, or divisor
    logic [DW-1:0]           r_acc;
    logic [DW-1:0]           r_rem;
    logic                    r_neg;
    logic [SCALC_STEP_W-1:0] r_cnt;

    logic [DW-1:0] w_p;
    logic [DW-1:0] w_q;
    logic          w_cin;
    logic [DW:0]   w_sum;
    logic [DW-1:0] w_shift;
    logic          w_last;

    assign w_shift = {r_rem[DW-2:0], r_x[DW-1]};
    assign w_last  = (r_cnt == {SCALC_STEP_W{1'b1}});

    // Operand select of the shared adder
    always_comb begin
        w_p   = r_x;
        w_q   = '0;
        w_cin = 1'b0;
        case (r_state)
            A_IDLE: begin
                w_p = i_a;
                if (i_req.op == OP_SUB) begin
                    w_q   = ~i_b;
                    w_cin = 1'b1;
                end else begin
                    w_q = i_b;
                end
            end
            A_PREPA: begin
                w_p   = r_x[DW-1] ? ~r_x : r_x;
                w_cin = r_x[DW-1];
            end
            A_PREPB: begin
                w_p   = r_y[DW-1] ? ~r_y : r_y;
                w_cin = r_y[DW-1];
            end
            A_MUL: begin
                w_p = r_acc;
                w_q = r_y[0] ? r_x : '0;
            end
            A_DIV: begin
                w_p   = w_shift;
                w_q   = ~r_y;
                w_cin = 1'b1;
            end
            A_FIX: begin
                // differing signs: exact gives -q, inexact gives -q-1 = ~q
                w_p   = r_neg ? ~r_x : r_x;
                w_cin = r_neg && (r_rem == '0);
            end
            default: begin
                w_p = r_x;
            end
        endcase
    end

    assign w_sum = {1'b0, w_p} + {1'b0, w_q} + (DW+1)'(w_cin);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= A_IDLE;
        end else begin
            case (r_state)
                A_IDLE: begin
                    if (i_req.start) begin
                        r_neg <= i_a[DW-1] ^ i_b[DW-1];
                        r_x   <= i_a;
                        r_y   <= i_b;
                        r_rem <= '0;
                        r_cnt <= '0;
                        case (i_req.op)
                            OP_MUL: begin
                                r_acc   <= '0;
                                r_state <= A_MUL;
                            end
                            OP_DIV:  r_state <= A_PREPA;
                            default: begin
                                r_acc   <= w_sum[DW-1:0];
                                r_state <= A_DONE;
                            end
                        endcase
                    end
                end
                A_PREPA: begin
                    r_x     <= w_sum[DW-1:0];
                    r_state <= A_PREPB;
                end
                A_PREPB: begin
                    r_y     <= w_sum[DW-1:0];
                    r_state <= A_DIV;
                end
                A_MUL: begin
                    r_acc <= w_sum[DW-1:0];
                    r_x   <= {r_x[DW-2:0], 1'b0};
                    r_y   <= {1'b0, r_y[DW-1:1]};
                    r_cnt <= r_cnt + 1'b1;
                    if (w_last) begin
                        r_state <= A_DONE;
                    end
                end
                A_DIV: begin
                    // carry out means the trial subtract did not borrow
                    r_rem <= w_sum[DW] ? w_sum[DW-1:0] : w_shift;
                    r_x   <= {r_x[DW-2:0], w_sum[DW]};
                    r_cnt <= r_cnt + 1'b1;
                    if (w_last) begin
                        r_state <= A_FIX;
                    end
                end
                A_FIX: begin
                    r_acc   <= w_sum[DW-1:0];
                    r_state <= A_DONE;
                end
                A_DONE: begin
                    r_state <= A_IDLE;
                end
                default: begin
                    r_state <= A_IDLE;
                end
            endcase
        end
    end

    assign o_done   = (r_state == A_DONE);
    assign o_result = r_acc;

endmodule

// ----- design/stack_calculator_engine.sv -----
// ----------------------------------------------------------------------------
// stack_calculator_engine
// Reverse-Polish calculator on a fixed-depth stack of signed 32-bit words,
// with push, pop, indexed reads and add/sub/mul/floor-divide of the top two.
// ----------------------------------------------------------------------------
//
//  channel  | valid    | ready    | payload
//  ---------+----------+----------+---------------------------------
//  input    | i_valid  | o_ready  | i_item (op, value, index)
//  output   | o_valid  | i_ready  | o_item (result, status, depth)
//
//  One item at a time. Each item passes the first check, then goes to the
//  reply (push, errors of the check), through a store read (pop, reads),
//  through both operand reads (divide by zero), or to the shared adder in
//  scalc_alu, where multiply and divide run over its 32 steps. The input
//  is ready again in the cycle after the result is loaded. The result
//  register frees the input side: the next item is taken while a result
//  still waits. Reset (i_rst_n low, sync) empties the stack; the stack words
//  are not cleared. A stalled result holds the sequencer in its reply state.
//
module stack_calculator_engine #(
    parameter int STACK_DEPTH = scalc_pkg::SCALC_STACK_DEPTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  scalc_pkg::t_in_item  i_item,
    output logic                 o_valid,
    input  logic                 i_ready,
    output scalc_pkg::t_out_item o_item
);
    import scalc_pkg::*;

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);
    // common width for compares and index arithmetic
    localparam int WW = (CW > SCALC_DEPTH_W) ? CW : SCALC_DEPTH_W;

    typedef enum logic [2:0] {
        S_IDLE, S_CHECK, S_RD_WAIT, S_OPB, S_OPA, S_ALU, S_REPLY
    } t_state;

    t_state                   r_state;
    logic [CW-1:0]            r_count;
    t_op                      r_op;
    logic [SCALC_DATA_W-1:0]  r_val;
    logic [SCALC_INDEX_W-1:0] r_idx;
    logic [SCALC_DATA_W-1:0]  r_b;
    logic [SCALC_DATA_W-1:0]  r_res;
    t_status                  r_st;
    logic                     r_out_valid;
    t_out_item                r_out;

    logic                     w_we;
    logic [AW-1:0]            w_waddr;
    logic [SCALC_DATA_W-1:0]  w_wdata;
    logic [AW-1:0]            w_raddr;
    logic [SCALC_DATA_W-1:0]  w_rdata;
    t_alu_req                 w_alu_req;
    logic                     w_alu_done;
    logic [SCALC_DATA_W-1:0]  w_alu_res;

    logic [WW-1:0]            w_cnt_ext;
    logic [WW-1:0]            w_idx_ext;
    logic [CW-1:0]            w_cnt_m1;
    logic [CW-1:0]            w_cnt_m2;
    logic [WW-1:0]            w_top_addr;
    logic                     w_full;
    logic                     w_empty;
    logic                     w_few;
    logic                     w_range;
    logic                     w_divzero;
    logic                     w_out_load;

    assign w_cnt_ext  = WW'(r_count);
    assign w_idx_ext  = WW'(r_idx);
    assign w_cnt_m1   = r_count - 1'b1;
    assign w_cnt_m2   = r_count - CW'(2);
    assign w_top_addr = w_cnt_ext - WW'(1) - w_idx_ext;
    assign w_full     = (r_count == CW'(STACK_DEPTH));
    assign w_empty    = (r_count == '0);
    assign w_few      = (r_count < CW'(2));
    assign w_range    = (w_idx_ext >= w_cnt_ext);
    assign w_divzero  = (r_op == OP_DIV) && (r_b == '0);
    // load the result register once it is free or being emptied
    assign w_out_load = (r_state == S_REPLY) && (!r_out_valid || i_ready);

    // Store access: writes for push and for the arithmetic result,
    // reads of the top, the entry below it, or an indexed entry
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_count[AW-1:0];
        w_wdata = r_val;
        w_raddr = w_cnt_m1[AW-1:0];
        case (r_state)
            S_CHECK: begin
                case (r_op)
                    OP_PUSH: w_we    = !w_full;
                    OP_RTOP: w_raddr = w_top_addr[AW-1:0];
                    OP_RBOT: w_raddr = w_idx_ext[AW-1:0];
                    default: w_raddr = w_cnt_m1[AW-1:0];
                endcase
            end
            S_OPB: begin
                w_raddr = w_cnt_m2[AW-1:0];
            end
            S_ALU: begin
                w_we    = w_alu_done;
                w_waddr = w_cnt_m2[AW-1:0];
                w_wdata = w_alu_res;
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    // Start the shared unit once both operands are in hand
    always_comb begin
        w_alu_req.op    = r_op;
        w_alu_req.start = (r_state == S_OPA) && !w_divzero;
    end

    scalc_mem #(
        .DEPTH  (STACK_DEPTH),
        .ADDR_W (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // A arrives from the store in S_OPA; B was captured into r_b in S_OPB
    scalc_alu u_alu (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (w_alu_req),
        .i_a      (w_rdata),
        .i_b      (r_b),
        .o_done   (w_alu_done),
        .o_result (w_alu_res)
    );

    // Sequencer, stack count and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_op    <= i_item.op;
                        r_val   <= i_item.value;
                        r_idx   <= i_item.index;
                        r_res   <= '0;
                        r_st    <= ST_OK;
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    case (r_op)
                        OP_PUSH: begin
                            r_state <= S_REPLY;
                            if (w_full) begin
                                r_st <= ST_FULL;
                            end else begin
                                r_count <= r_count + 1'b1;
                            end
                        end
                        OP_POP: begin
                            if (w_empty) begin
                                r_st    <= ST_EMPTY;
                                r_state <= S_REPLY;
                            end else begin
                                r_count <= w_cnt_m1;
                                r_state <= S_RD_WAIT;
                            end
                        end
                        OP_RTOP, OP_RBOT: begin
                            if (w_range) begin
                                r_st    <= ST_RANGE;
                                r_state <= S_REPLY;
                            end else begin
                                r_state <= S_RD_WAIT;
                            end
                        end
                        default: begin
                            if (w_few) begin
                                r_st    <= ST_FEW;
                                r_state <= S_REPLY;
                            end else begin
                                r_state <= S_OPB;
                            end
                        end
                    endcase
                end
                S_RD_WAIT: begin
                    r_res   <= w_rdata;
                    r_state <= S_REPLY;
                end
                S_OPB: begin
                    r_b     <= w_rdata;
                    r_state <= S_OPA;
                end
                S_OPA: begin
                    if (w_divzero) begin
                        r_st    <= ST_DIVZERO;
                        r_state <= S_REPLY;
                    end else begin
                        r_state <= S_ALU;
                    end
                end
                S_ALU: begin
                    if (w_alu_done) begin
                        r_res   <= w_alu_res;
                        r_count <= w_cnt_m1;
                        r_state <= S_REPLY;
                    end
                end
                S_REPLY: begin
                    // hold until the result register is free
                    if (w_out_load) begin
                        r_out.result <= r_res;
                        r_out.status <= r_st;
                        r_out.depth  <= w_cnt_ext[SCALC_DEPTH_W-1:0];
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_out_valid;
    assign o_item  = r_out;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(STACK_DEPTH))
        else $error("stack count above depth");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("item accepted while busy");

    a_alu_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_alu_done |-> (r_state == S_ALU))
        else $error("arithmetic result outside wait state");

    a_no_div_by_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_alu_req.start && (w_alu_req.op == OP_DIV)) |-> (r_b != '0))
        else $error("divide by zero reached the unit");
`endif

endmodule

// ----- dv/stack_calculator_engine_tb.sv -----
// ----------------------------------------------------------------------------
// stack_calculator_engine_tb
// Self-checking bench for the stack calculator. It drives operation items and
// predicts each reply with its own copy of the stack. It checks the reply
// result, status and depth in order. Directed error and overflow cases come
// first, then a fill to full depth and a drain back to empty, then random
// phases under varied valid/ready pressure.
// ----------------------------------------------------------------------------
module stack_calculator_engine_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import scalc_pkg::*;

    localparam int DEPTH         = SCALC_STACK_DEPTH;
    localparam int QUIET_LIMIT   = 5000;  // cycles with no handshake on either side
    localparam int SETTLE_CYCLES = 60;    // longer than the slowest operation
    localparam int MAX_REPORTS   = 10;

    localparam logic [31:0] WORD_MIN = 32'h8000_0000;
    localparam logic [31:0] WORD_MAX = 32'h7fff_ffff;
    localparam logic [31:0] WORD_NEG1 = 32'hffff_ffff;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_valid;
    logic      o_ready;
    t_in_item  i_item;
    logic      o_valid;
    logic      i_ready;
    t_out_item o_item;

    stack_calculator_engine uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_item  (i_item),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_item  (o_item)
    );

    // Our own copy of the stack, advanced once per accepted item.
    logic [31:0] stk_words [DEPTH];
    int          stk_count = 0;

    // Replies predicted for accepted items, oldest first.
    t_out_item   pending_replies [$];
    t_out_item   reply_want;

    int mismatch_count = 0;
    int quiet_cycles   = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    // ------------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Predict the reply of one operation and update the stack copy.
    // Any error leaves the stack as it was.
    // ------------------------------------------------------------------------
    function automatic t_out_item apply_rpn_op(t_in_item it);
        t_out_item   r;
        logic [31:0] a;
        logic [31:0] b;
        longint      sa;
        longint      sb;
        longint      q;
        r.result = '0;
        r.status = ST_OK;
        case (it.op)
            OP_PUSH: begin
                if (stk_count >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    stk_words[stk_count] = it.value;
                    stk_count++;
                end
            end
            OP_POP: begin
                if (stk_count == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    stk_count--;
                    r.result = stk_words[stk_count];
                end
            end
            OP_RTOP, OP_RBOT: begin
                if (int'(it.index) >= stk_count) begin
                    r.status = ST_RANGE;
                end else if (it.op == OP_RTOP) begin
                    r.result = stk_words[stk_count - 1 - int'(it.index)];
                end else begin
                    r.result = stk_words[it.index];
                end
            end
            default: begin
                if (stk_count < 2) begin
                    r.status = ST_FEW;
                end else begin
                    b = stk_words[stk_count - 1];
                    a = stk_words[stk_count - 2];
                    case (it.op)
                        OP_ADD: r.result = a + b;
                        OP_SUB: r.result = a - b;
                        OP_MUL: r.result = a * b;
                        OP_DIV: begin
                            if (b == '0) begin
                                r.status = ST_DIVZERO;
                            end else begin
                                // Truncate, then step toward minus infinity when
                                // the signs differ and something is left over.
                                sa = longint'($signed(a));
                                sb = longint'($signed(b));
                                q  = sa / sb;
                                if ((sa % sb) != 0 && ((sa < 0) != (sb < 0))) begin
                                    q = q - 1;
                                end
                                r.result = q[31:0];
                            end
                        end
                        default: r.status = ST_OK;
                    endcase
                    if (r.status == ST_OK) begin
                        stk_count--;
                        stk_words[stk_count - 1] = r.result;
                    end
                end
            end
        endcase
        r.depth = stk_count[SCALC_DEPTH_W-1:0];
        return r;
    endfunction

    // Half corner words, some small values, the rest full random so every bit toggles.
    function automatic logic [31:0] rand_word();
        case ($urandom_range(9))
            0:       return WORD_MIN;
            1:       return WORD_MAX;
            2:       return '0;
            3:       return WORD_NEG1;
            4:       return 32'd1;
            5, 6:    return 32'($signed($urandom_range(40)) - 20);
            default: return $urandom;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Send one item. Called and returning at a falling edge; valid is left
    // high so back-to-back items need no extra assignment.
    // ------------------------------------------------------------------------
    task automatic send_item(input t_op op, input logic [31:0] value,
                             input logic [9:0] index);
        t_in_item it;
        it.op    = op;
        it.value = value;
        it.index = index;
        // Idle cycle by cycle at the configured rate.
        if ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            do @(negedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_item  <= it;
        i_valid <= 1'b1;
        do @(posedge i_clk); while (!o_ready);
        pending_replies.push_back(apply_rpn_op(it));
        @(negedge i_clk);
    endtask

    // Drop valid, drain all replies, then let the block go quiet.
    task automatic wait_settled();
        i_valid <= 1'b0;
        while (pending_replies.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    // ------------------------------------------------------------------------
    // Directed: every error status on an empty or short stack, wrap on
    // add/sub/mul, the most negative word over -1, floor rounding, and the
    // read extremes.
    // ------------------------------------------------------------------------
    task automatic test_directed();
        send_item(OP_POP,  $urandom, 10'd0);      // empty
        send_item(OP_RTOP, $urandom, 10'd0);      // read with nothing there
        send_item(OP_RBOT, $urandom, 10'd1023);
        send_item(OP_ADD,  $urandom, 10'd0);      // too few operands
        send_item(OP_PUSH, WORD_MIN, 10'd1023);
        send_item(OP_DIV,  $urandom, 10'd0);      // one operand only
        send_item(OP_PUSH, WORD_NEG1, 10'd0);
        send_item(OP_DIV,  $urandom, 10'd0);      // wraps to the most negative word
        send_item(OP_PUSH, 32'd0, 10'd0);
        send_item(OP_DIV,  $urandom, 10'd0);      // divide by zero, stack kept
        send_item(OP_RTOP, $urandom, 10'd0);
        send_item(OP_RBOT, $urandom, 10'd0);
        send_item(OP_RTOP, $urandom, 10'd2);      // index equal to depth
        send_item(OP_POP,  $urandom, 10'd0);
        send_item(OP_PUSH, 32'd1, 10'd0);
        send_item(OP_SUB,  $urandom, 10'd0);      // min - 1 wraps to max
        send_item(OP_PUSH, WORD_MAX, 10'd0);
        send_item(OP_ADD,  $urandom, 10'd0);      // max + max wraps
        send_item(OP_PUSH, 32'd7, 10'd0);
        send_item(OP_DIV,  $urandom, 10'd0);      // -2 / 7 floors to -1
        send_item(OP_PUSH, 32'h0001_0000, 10'd0);
        send_item(OP_PUSH, 32'h0001_0000, 10'd0);
        send_item(OP_MUL,  $urandom, 10'd0);      // 2^32 wraps to zero
        send_item(OP_MUL,  $urandom, 10'd0);
        send_item(OP_POP,  $urandom, 10'd0);
        wait_settled();
    endtask

    // ------------------------------------------------------------------------
    // Fill to full depth, hit the full status and the last index from both
    // ends, then drain to empty through pops and arithmetic.
    // ------------------------------------------------------------------------
    task automatic test_full_stack();
        t_op op;
        while (stk_count < DEPTH) begin
            send_item(OP_PUSH, rand_word(), 10'($urandom_range(1023)));
        end
        send_item(OP_PUSH, rand_word(), 10'd0);   // full
        send_item(OP_RTOP, $urandom, 10'd1023);
        send_item(OP_RBOT, $urandom, 10'd1023);
        send_item(OP_MUL,  $urandom, 10'd0);
        send_item(OP_PUSH, rand_word(), 10'd0);
        send_item(OP_PUSH, rand_word(), 10'd0);   // full again
        while (stk_count > 0) begin
            case ($urandom_range(9))
                0, 1, 2, 3: op = OP_POP;
                default:    op = t_op'($urandom_range(7, 4));
            endcase
            send_item(op, $urandom, 10'($urandom_range(1023)));
        end
        wait_settled();
    endtask

    // ------------------------------------------------------------------------
    // Random walk of the depth around small values so arithmetic, reads and
    // the low-depth errors all come up often.
    // ------------------------------------------------------------------------
    task automatic test_random(input int count);
        int          roll;
        int          push_pct;
        t_op         op;
        logic [9:0]  idx;
        for (int n = 0; n < count; n++) begin
            roll     = $urandom_range(99);
            push_pct = (stk_count < 3) ? 60 : (stk_count > 40) ? 20 : 40;
            if (roll < push_pct) begin
                op = OP_PUSH;
            end else if (roll < push_pct + 12) begin
                op = OP_POP;
            end else if (roll < push_pct + 24) begin
                op = ($urandom_range(1) != 0) ? OP_RTOP : OP_RBOT;
            end else begin
                op = t_op'($urandom_range(7, 4));
            end
            // Mostly valid indexes, some anywhere in the field.
            if (stk_count > 0 && $urandom_range(9) < 7) begin
                idx = 10'($urandom_range(stk_count - 1));
            end else begin
                idx = 10'($urandom_range(1023));
            end
            send_item(op, rand_word(), idx);
        end
        wait_settled();
    endtask

    // ------------------------------------------------------------------------
    // Receiver: stall cycle by cycle at the configured rate.
    // ------------------------------------------------------------------------
    initial begin
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            i_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Reply check: compare each accepted reply with the oldest prediction.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_replies.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS) begin
                    $display("%0t: reply with none pending: result %0d status %0d depth %0d",
                             $realtime, o_item.result, o_item.status, o_item.depth);
                end
            end else begin
                reply_want = pending_replies.pop_front();
                if (o_item.result !== reply_want.result ||
                    o_item.status !== reply_want.status ||
                    o_item.depth  !== reply_want.depth) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS) begin
                        $display({"%0t: reply mismatch: expected result %0d status %0d",
                                  " depth %0d, got result %0d status %0d depth %0d"},
                                 $realtime, reply_want.result, reply_want.status,
                                 reply_want.depth, o_item.result, o_item.status,
                                 o_item.depth);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: end the run if neither channel moves for too long.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("stack_calculator_engine_tb NOT OK");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_item  = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        set_idling(0, 0);
        test_directed();
        set_idling(25, 25);
        test_full_stack();

        set_idling(0, 0);
        test_random(50);
        set_idling(49, 0);
        test_random(50);
        set_idling(0, 49);
        test_random(50);
        set_idling(25, 25);
        test_random(50);

        if (mismatch_count == 0 && pending_replies.size() == 0) begin
            $display("stack_calculator_engine_tb OK");
        end else begin
            $display("stack_calculator_engine_tb NOT OK");
        end
        $finish;
    end

endmodule
